[rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, quiet while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an expression never holds.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

[rtl/sfcrb_pkg.sv]
// Package: payload types, command and register codes, default depths.
package sfcrb_pkg;

  localparam int unsigned RX_DEPTH_DEF = 128;
  localparam int unsigned TX_DEPTH_DEF = 256;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LINK = 2'd0;  // link byte exchanged
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd1;  // host pushes a reply byte
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd2;  // host pops a received byte

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE   = 1'd1;

  localparam logic [BYTE_W-1:0] START_CODE_RST = 8'd1;
  localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'd13;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] link_out_byte;
    logic [BYTE_W-1:0] host_byte;
    logic              host_byte_valid;
    logic              frame_complete;
    logic              dropped;
  } out_t;

endpackage

[rtl/spi_framed_command_reply_buffer.sv]
// Top level: framed command/reply byte buffer with receive and reply ring queues.
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+---------------------------------
//  input    | start, busy, in_data               | beat taken when start && !busy
//  result   | out_valid, out_data                | one-cycle strobe, cannot be held
//  config   | cfg_valid, cfg_ready, cfg_index,   | write taken when valid && ready
//           | cfg_data                           |
//
// One beat is taken every clock; busy stays low. Each beat gives exactly one
// result, strobed on out_valid in the cycle after the beat is taken, so the
// rate is one beat a clock. The result timing is set by the registered read
// port of each queue memory: the queue word at the head pointer is read at
// the same edge that takes the beat.
// Reset is synchronous, active low; it clears pointers, levels and frame
// state and restores the default codes. Queue contents are left as they are.
// The receiver cannot stall, so nothing backs up behind the result register.
`include "assert_macros.svh"

module spi_framed_command_reply_buffer
  import sfcrb_pkg::*;
#(
  parameter int unsigned RX_DEPTH = RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input beats
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  // results
  output logic                 out_valid,
  output out_t                 out_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  localparam int unsigned RX_PW = $clog2(RX_DEPTH);
  localparam int unsigned TX_PW = $clog2(TX_DEPTH);
  localparam int unsigned RX_LW = $clog2(RX_DEPTH + 1);
  localparam int unsigned TX_LW = $clog2(TX_DEPTH + 1);

  localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(RX_DEPTH - 1);
  localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);
  localparam logic [RX_LW-1:0] RX_FULL = RX_LW'(RX_DEPTH);
  localparam logic [TX_LW-1:0] TX_FULL = TX_LW'(TX_DEPTH);

  // Queue memories; no reset, every entry that reaches the output is written first.
  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];

  // Configuration
  logic [BYTE_W-1:0] start_code_r;
  logic [BYTE_W-1:0] end_code_r;

  // Queue and frame state
  logic [RX_PW-1:0] rx_wp_r, rx_wp_nxt;
  logic [RX_PW-1:0] rx_rp_r, rx_rp_nxt;
  logic [RX_LW-1:0] rx_level_r, rx_level_nxt;
  logic [TX_PW-1:0] tx_wp_r, tx_wp_nxt;
  logic [TX_PW-1:0] tx_rp_r, tx_rp_nxt;
  logic [TX_LW-1:0] tx_level_r, tx_level_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic             reply_en_r, reply_en_nxt;

  // Per-beat decisions
  logic accept;
  logic frame_open;
  logic rx_we, tx_we;
  logic take, pop_hit, complete, drop;

  // Result register
  logic              out_valid_r;
  logic              take_r, pop_hit_r, complete_r, drop_r;
  logic [BYTE_W-1:0] tx_rd_r, rx_rd_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Work out the whole effect of one beat on the queues and the frame state.
  always_comb begin
    rx_wp_nxt    = rx_wp_r;
    rx_rp_nxt    = rx_rp_r;
    rx_level_nxt = rx_level_r;
    tx_wp_nxt    = tx_wp_r;
    tx_rp_nxt    = tx_rp_r;
    tx_level_nxt = tx_level_r;
    in_frame_nxt = in_frame_r;
    reply_en_nxt = reply_en_r;
    frame_open   = 1'b0;
    rx_we        = 1'b0;
    tx_we        = 1'b0;
    take         = 1'b0;
    pop_hit      = 1'b0;
    complete     = 1'b0;
    drop         = 1'b0;
    if (accept) begin
      unique case (in_data.command)
        CMD_LINK: begin
          // Start code while idle opens a frame and flushes pending replies.
          frame_open = !in_frame_r && (in_data.data == start_code_r);
          if (frame_open) begin
            in_frame_nxt = 1'b1;
            if (tx_level_r != '0) begin
              tx_level_nxt = '0;
              tx_wp_nxt    = '0;
              tx_rp_nxt    = '0;
            end
          end
          // Inside a frame: store every byte, drop it when the queue is full.
          if (in_frame_r || frame_open) begin
            if (rx_level_r != RX_FULL) begin
              rx_we        = 1'b1;
              rx_wp_nxt    = (rx_wp_r == RX_LAST) ? '0 : rx_wp_r + 1'b1;
              rx_level_nxt = rx_level_r + 1'b1;
            end else begin
              drop = 1'b1;
            end
            if (in_data.data == end_code_r) begin
              in_frame_nxt = 1'b0;
              reply_en_nxt = 1'b1;
              complete     = 1'b1;
            end
          end
          // Send the head reply byte; a flush leaves the level at zero here.
          if (reply_en_nxt && (tx_level_nxt != '0)) begin
            take         = 1'b1;
            tx_rp_nxt    = (tx_rp_r == TX_LAST) ? '0 : tx_rp_r + 1'b1;
            tx_level_nxt = tx_level_r - 1'b1;
            if (tx_level_r == TX_LW'(1)) begin
              reply_en_nxt = 1'b0;
            end
          end
        end
        CMD_PUSH: begin
          if (tx_level_r != TX_FULL) begin
            tx_we        = 1'b1;
            tx_wp_nxt    = (tx_wp_r == TX_LAST) ? '0 : tx_wp_r + 1'b1;
            tx_level_nxt = tx_level_r + 1'b1;
          end else begin
            drop = 1'b1;
          end
        end
        CMD_POP: begin
          if (rx_level_r != '0) begin
            pop_hit      = 1'b1;
            rx_rp_nxt    = (rx_rp_r == RX_LAST) ? '0 : rx_rp_r + 1'b1;
            rx_level_nxt = rx_level_r - 1'b1;
          end
        end
        default: begin
          // unused command: no state change, all-zero result
        end
      endcase
    end
  end

  // Control state, configuration and result flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= START_CODE_RST;
      end_code_r   <= END_CODE_RST;
      rx_wp_r      <= '0;
      rx_rp_r      <= '0;
      rx_level_r   <= '0;
      tx_wp_r      <= '0;
      tx_rp_r      <= '0;
      tx_level_r   <= '0;
      in_frame_r   <= 1'b0;
      reply_en_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      take_r       <= 1'b0;
      pop_hit_r    <= 1'b0;
      complete_r   <= 1'b0;
      drop_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_START_CODE: start_code_r <= cfg_data;
          REG_END_CODE:   end_code_r   <= cfg_data;
          default: ;
        endcase
      end
      rx_wp_r     <= rx_wp_nxt;
      rx_rp_r     <= rx_rp_nxt;
      rx_level_r  <= rx_level_nxt;
      tx_wp_r     <= tx_wp_nxt;
      tx_rp_r     <= tx_rp_nxt;
      tx_level_r  <= tx_level_nxt;
      in_frame_r  <= in_frame_nxt;
      reply_en_r  <= reply_en_nxt;
      out_valid_r <= accept;
      take_r      <= take;
      pop_hit_r   <= pop_hit;
      complete_r  <= complete;
      drop_r      <= drop;
    end
  end

  // Queue memories: one write port, registered read at the head pointer.
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_wp_r] <= in_data.data;
    end
    rx_rd_r <= rx_mem[rx_rp_r];
  end

  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_wp_r] <= in_data.data;
    end
    tx_rd_r <= tx_mem[tx_rp_r];
  end

  // Zero each byte that the beat did not produce.
  assign out_valid                = out_valid_r;
  assign out_data.link_out_byte   = take_r    ? tx_rd_r : '0;
  assign out_data.host_byte       = pop_hit_r ? rx_rd_r : '0;
  assign out_data.host_byte_valid = pop_hit_r;
  assign out_data.frame_complete  = complete_r;
  assign out_data.dropped         = drop_r;

  // Every taken beat yields its result on the next cycle.
  `ASSERT_CLK(a_result_follows, accept |=> out_valid_r, "taken beat gave no result")
  // Levels never run past the queue depth.
  `ASSERT_NEVER(a_rx_level, rx_level_r > RX_FULL, "receive level above depth")
  `ASSERT_NEVER(a_tx_level, tx_level_r > TX_FULL, "reply level above depth")
  // A pop never sends a reply byte and never drops.
  `ASSERT_NEVER(a_excl, pop_hit_r && (take_r || drop_r), "result flags from mixed commands")

endmodule
